/* src/flm_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flm_pkg
// Shared types, constants and helpers of the fixed-string line matcher.
// ---------------------------------------------------------------------------
package flm_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int LINE_W          = 32;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_INDEX_W     = 3;
  localparam int PLEN_W          = 5;
  localparam int PATTERN_W       = 2 * CFG_DATA_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_FIRST = 3'd0,
    REG_PATTERN_LAST  = 3'd1,
    REG_PATTERN_LEN   = 3'd2,
    REG_IGNORE_CASE   = 3'd3,
    REG_REPORT_MODE   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       file_start;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [LINE_W-1:0] matched_line_number;
    logic              any_match_seen;
    logic              file_first_hit;
  } out_item_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_write_t;

  typedef struct packed {
    logic [PATTERN_W-1:0] pattern;
    logic [PLEN_W-1:0]    pattern_length;
    logic                 ignore_case;
    logic                 report_mode;
  } cfg_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic ic);
    logic [7:0] r;
    r = c;
    if (ic && (c >= 8'h41) && (c <= 8'h5A)) begin
      r = c | 8'h20;
    end
    return r;
  endfunction

endpackage

/* src/flm_stream_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flm_stream_if
// Valid/ready channel carrying one payload per transfer.
// ---------------------------------------------------------------------------
interface flm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/flm_cfg_regs.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flm_cfg_regs
// Configuration register file, written through its own valid/ready channel.
// ---------------------------------------------------------------------------
module flm_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  flm_stream_if.sink          cfg_if,
  output flm_pkg::cfg_t       cfg
);

  flm_pkg::cfg_t cfg_r;
  flm_pkg::cfg_t cfg_nxt;

  assign cfg_if.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      unique case (cfg_if.data.index)
        flm_pkg::REG_PATTERN_FIRST: begin
          cfg_nxt.pattern[flm_pkg::CFG_DATA_W-1:0] = cfg_if.data.data;
        end
        flm_pkg::REG_PATTERN_LAST: begin
          cfg_nxt.pattern[flm_pkg::PATTERN_W-1:flm_pkg::CFG_DATA_W] = cfg_if.data.data;
        end
        flm_pkg::REG_PATTERN_LEN: begin
          cfg_nxt.pattern_length = cfg_if.data.data[flm_pkg::PLEN_W-1:0];
        end
        flm_pkg::REG_IGNORE_CASE: begin
          cfg_nxt.ignore_case = cfg_if.data.data[0];
        end
        flm_pkg::REG_REPORT_MODE: begin
          cfg_nxt.report_mode = cfg_if.data.data[0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* src/flm_window_match.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flm_window_match
// Window of recent line bytes and the parallel pattern comparison.
// ---------------------------------------------------------------------------
module flm_window_match #(
  parameter int MAX_PATTERN = flm_pkg::MAX_PATTERN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  flm_pkg::in_item_t item,
  input  flm_pkg::cfg_t     cfg,
  output logic              window_hit
);

  localparam int WIN = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
  localparam int LW  = $clog2(MAX_PATTERN + 1);
  localparam int IW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [LW-1:0] PMAX = LW'(MAX_PATTERN);

  logic [7:0]    win_r [WIN];
  logic [LW-1:0] bil_r;
  logic [LW-1:0] bil_nxt;
  logic [LW-1:0] bil_eff;
  logic [LW-1:0] filled;
  logic [LW-1:0] len;
  logic [7:0]    pat   [MAX_PATTERN];
  logic [7:0]    txt   [MAX_PATTERN];
  logic [IW-1:0] pidx  [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq;

  assign len = (cfg.pattern_length > flm_pkg::PLEN_W'(MAX_PATTERN)) ? PMAX
             : LW'(cfg.pattern_length);
  assign bil_eff = item.file_start ? '0 : bil_r;
  assign filled  = (bil_eff == PMAX) ? PMAX : LW'(bil_eff + LW'(1));

  for (genvar b = 0; b < MAX_PATTERN; b++) begin : g_cmp
    assign pat[b] = cfg.pattern[8*b +: 8];
    if (b == 0) begin : g_cur
      assign txt[b] = item.text_byte;
    end else begin : g_win
      assign txt[b] = win_r[b-1];
    end
    assign pidx[b] = IW'(len - LW'(b) - LW'(1));
    assign eq[b] = (LW'(b) >= len) ||
                   (flm_pkg::fold_byte(txt[b], cfg.ignore_case) ==
                    flm_pkg::fold_byte(pat[pidx[b]], cfg.ignore_case));
  end

  assign window_hit = (&eq) && (filled >= len);
  assign bil_nxt    = item.line_end ? '0 : filled;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bil_r <= '0;
    end else if (step) begin
      bil_r <= bil_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && !item.line_end) begin
      win_r[0] <= item.text_byte;
      for (int k = 1; k < WIN; k++) begin
        win_r[k] <= win_r[k-1];
      end
    end
  end

endmodule

/* src/fixed_string_line_matcher.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fixed_string_line_matcher
// Searches each line of a byte stream for a configured fixed string.
//
//   Channel  Dir   Payload                                             Role
//   in_if    sink  text_byte, file_start, line_end                     text
//   out_if   src   matched_line_number, any_match_seen, file_first_hit hits
//   cfg_if   sink  index, data                                         setup
//
// One byte per cycle sustained while results are taken; a byte transferred in
// is held in the input register, and its result in the result register.
// The window compare and line state update happen in the same cycle.
// Synchronous active-low reset clears control state; no clearing pass.
// A stalled result holds the pipeline only when the input register is full.
// ---------------------------------------------------------------------------
module fixed_string_line_matcher #(
  parameter int MAX_PATTERN = flm_pkg::MAX_PATTERN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  flm_stream_if.sink   in_if,
  flm_stream_if.source out_if,
  flm_stream_if.sink   cfg_if
);

  localparam logic [flm_pkg::LINE_W-1:0] LINE_MAX = '1;
  localparam logic [flm_pkg::LINE_W-1:0] LINE_ONE = flm_pkg::LINE_W'(1);

  flm_pkg::cfg_t      cfg;
  flm_pkg::in_item_t  in_item_r;
  flm_pkg::in_item_t  in_item_nxt;
  flm_pkg::out_item_t out_item_r;
  flm_pkg::out_item_t out_item_nxt;
  logic               in_valid_r;
  logic               in_valid_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [flm_pkg::LINE_W-1:0] line_count_r;
  logic [flm_pkg::LINE_W-1:0] line_count_nxt;
  logic [flm_pkg::LINE_W-1:0] line_eff;
  logic               line_hit_r;
  logic               line_hit_nxt;
  logic               file_done_r;
  logic               file_done_nxt;
  logic               sticky_r;
  logic               sticky_nxt;
  logic               out_free;
  logic               step;
  logic               window_hit;
  logic               hit;
  logic               hit_eff;
  logic               done_eff;
  logic               rep_first;
  logic               rep_line;

  flm_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  flm_window_match #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_match (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .item       (in_item_r),
    .cfg        (cfg),
    .window_hit (window_hit)
  );

  assign out_free    = !out_valid_r || out_if.ready;
  assign step        = in_valid_r && out_free;
  assign in_if.ready = !in_valid_r || out_free;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_item_r;

  assign line_eff  = in_item_r.file_start ? LINE_ONE : line_count_r;
  assign hit_eff   = in_item_r.file_start ? 1'b0 : line_hit_r;
  assign done_eff  = in_item_r.file_start ? 1'b0 : file_done_r;
  assign hit       = !done_eff && window_hit;
  assign rep_first = hit && cfg.report_mode;
  assign rep_line  = in_item_r.line_end && !cfg.report_mode && !done_eff &&
                     (hit_eff || hit);

  always_comb begin
    in_valid_nxt   = in_valid_r;
    in_item_nxt    = in_item_r;
    out_valid_nxt  = out_valid_r;
    out_item_nxt   = out_item_r;
    line_count_nxt = line_count_r;
    line_hit_nxt   = line_hit_r;
    file_done_nxt  = file_done_r;
    sticky_nxt     = sticky_r;

    if (step) begin
      in_valid_nxt = 1'b0;
    end
    if (in_if.valid && in_if.ready) begin
      in_valid_nxt = 1'b1;
      in_item_nxt  = in_if.data;
    end

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (step) begin
      out_valid_nxt = rep_first || rep_line;
      out_item_nxt.matched_line_number = line_eff;
      out_item_nxt.any_match_seen      = 1'b1;
      out_item_nxt.file_first_hit      = rep_first;
      file_done_nxt = done_eff || rep_first;
      sticky_nxt    = sticky_r || hit;
      if (in_item_r.line_end) begin
        line_hit_nxt   = 1'b0;
        line_count_nxt = (line_eff == LINE_MAX) ? line_eff
                       : flm_pkg::LINE_W'(line_eff + LINE_ONE);
      end else begin
        line_hit_nxt   = hit_eff || hit;
        line_count_nxt = line_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      line_count_r <= LINE_ONE;
      line_hit_r   <= 1'b0;
      file_done_r  <= 1'b0;
      sticky_r     <= 1'b0;
    end else begin
      in_valid_r   <= in_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      line_count_r <= line_count_nxt;
      line_hit_r   <= line_hit_nxt;
      file_done_r  <= file_done_nxt;
      sticky_r     <= sticky_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_item_r  <= in_item_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

/* src/flm_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flm_checker
// Port-level checks of the result channel of the line matcher.
// ---------------------------------------------------------------------------
module flm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input flm_pkg::out_item_t out_data
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_sticky_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.any_match_seen)
    else $error("result without any-match flag");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.matched_line_number != '0)
    else $error("line number zero");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");

endmodule

bind fixed_string_line_matcher flm_checker u_flm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);

/* sim/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the fixed-string line matcher.
//
// Text bytes stream into the block with random gaps while the result side
// stalls at random. A behavioral line matcher in the bench predicts every
// hit from the accepted bytes, and each result transfer is compared field
// by field against the oldest prediction. The pattern, its length, case
// folding and the report mode are reprogrammed between phases, sometimes
// in the middle of a line, with the extreme lengths among the settings.
// ---------------------------------------------------------------------------
module tb;
  import flm_pkg::*;

  localparam int NPAT = MAX_PATTERN_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int SETTLE = 8;
  localparam logic [7:0] NL = 8'h0A;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  flm_stream_if #(.payload_t(in_item_t))   text_ch ();
  flm_stream_if #(.payload_t(out_item_t))  hit_ch ();
  flm_stream_if #(.payload_t(cfg_write_t)) reg_ch ();

  fixed_string_line_matcher uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (text_ch),
    .out_if(hit_ch),
    .cfg_if(reg_ch)
  );

  // Predictor configuration and line state.
  logic [127:0] pat_bits;
  logic [4:0]   pat_len;
  logic         fold_on;
  logic         first_only;
  logic [7:0]   recent [NPAT];
  int unsigned  line_fill;
  logic [31:0]  line_no;
  logic         line_matched;
  logic         file_closed;
  logic         ever_matched;

  in_item_t  text_queue [$];
  out_item_t hits_due [$];

  int errors = 0;
  int items_made = 0;
  int bytes_in = 0;
  int results_seen = 0;
  int settings_used = 0;
  int gap_pct = 0;
  int gap_left = 0;
  int stall_pct = 0;
  int stall_left = 0;
  bit open_line = 1'b0;
  int unsigned cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (fold_on && c >= "A" && c <= "Z") return c + 8'd32;
    return c;
  endfunction

  function automatic void forget_line();
    for (int k = 0; k < NPAT; k++) recent[k] = 8'h00;
    line_fill = 0;
    line_matched = 1'b0;
  endfunction

  function automatic int unsigned active_len();
    return (pat_len > NPAT) ? NPAT : pat_len;
  endfunction

  function automatic bit scan_byte(input in_item_t it, output out_item_t res);
    int unsigned span;
    int unsigned filled;
    int unsigned back;
    logic [7:0]  t;
    bit          ok;
    bit          hit;
    hit = 1'b0;
    res = '0;
    span = active_len();
    if (it.file_start) begin
      forget_line();
      line_no = 32'd1;
      file_closed = 1'b0;
    end
    filled = (line_fill + 1 > NPAT) ? NPAT : line_fill + 1;
    if (!file_closed && filled >= span) begin
      ok = 1'b1;
      for (int j = 0; j < span; j++) begin
        back = span - 1 - j;
        t = (back == 0) ? it.text_byte : recent[back - 1];
        if (to_lower(t) != to_lower(pat_bits[j*8 +: 8])) ok = 1'b0;
      end
      if (ok) begin
        line_matched = 1'b1;
        ever_matched = 1'b1;
        if (first_only) begin
          res = '{matched_line_number: line_no, any_match_seen: 1'b1, file_first_hit: 1'b1};
          hit = 1'b1;
          file_closed = 1'b1;
        end
      end
    end
    if (!it.line_end) begin
      for (int k = NPAT - 1; k > 0; k--) recent[k] = recent[k-1];
      recent[0] = it.text_byte;
      line_fill = filled;
      return hit;
    end
    if (!hit && !file_closed && line_matched && !first_only) begin
      res = '{matched_line_number: line_no, any_match_seen: 1'b1, file_first_hit: 1'b0};
      hit = 1'b1;
    end
    if (line_no != 32'hFFFF_FFFF) line_no = line_no + 1;
    forget_line();
    return hit;
  endfunction

  always @(posedge clk) begin
    out_item_t res;
    if (!rst_n) begin
      text_ch.valid <= 1'b0;
    end else begin
      if (text_ch.valid && text_ch.ready) begin
        bytes_in++;
        if (scan_byte(text_ch.data, res)) hits_due.push_back(res);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) gap_left = $urandom_range(1, 6);
      end
      if (!text_ch.valid || text_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          text_ch.valid <= 1'b0;
        end else if (text_queue.size() != 0) begin
          text_ch.valid <= 1'b1;
          text_ch.data <= text_queue.pop_front();
        end else begin
          text_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      hit_ch.ready <= 1'b0;
    end else begin
      if (hit_ch.valid && hit_ch.ready) begin
        results_seen++;
        if (hits_due.size() == 0) begin
          $error("result with nothing expected: matched_line_number %0d",
                 hit_ch.data.matched_line_number);
          errors++;
        end else begin
          want = hits_due.pop_front();
          if (hit_ch.data.matched_line_number != want.matched_line_number) begin
            $error("matched_line_number: expected %0d, got %0d",
                   want.matched_line_number, hit_ch.data.matched_line_number);
            errors++;
          end
          if (hit_ch.data.any_match_seen !== want.any_match_seen) begin
            $error("any_match_seen: expected %0b, got %0b",
                   want.any_match_seen, hit_ch.data.any_match_seen);
            errors++;
          end
          if (hit_ch.data.file_first_hit !== want.file_first_hit) begin
            $error("file_first_hit: expected %0b, got %0b",
                   want.file_first_hit, hit_ch.data.file_first_hit);
            errors++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        hit_ch.ready <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 5);
        hit_ch.ready <= 1'b0;
      end else begin
        hit_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic wait_idle();
    int waited;
    waited = 0;
    while (text_queue.size() != 0 || text_ch.valid) @(posedge clk);
    while (hits_due.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    if (hits_due.size() != 0) begin
      $error("%0d expected results never arrived", hits_due.size());
      errors += hits_due.size();
      hits_due.delete();
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
    reg_ch.valid <= 1'b1;
    reg_ch.data <= {idx, val};
    @(posedge clk);
    while (!reg_ch.ready) @(posedge clk);
    case (idx)
      REG_PATTERN_FIRST: pat_bits[63:0] = val;
      REG_PATTERN_LAST:  pat_bits[127:64] = val;
      REG_PATTERN_LEN:   pat_len = val[4:0];
      REG_IGNORE_CASE:   fold_on = val[0];
      REG_REPORT_MODE:   first_only = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [4:0] len, input bit ic, input bit md);
    wait_idle();
    write_reg(REG_PATTERN_FIRST, lo);
    write_reg(REG_PATTERN_LAST, hi);
    write_reg(REG_PATTERN_LEN, {59'd0, len});
    write_reg(REG_IGNORE_CASE, {63'd0, ic});
    write_reg(REG_REPORT_MODE, {63'd0, md});
    reg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'("a" + $urandom_range(0, 25));
    if ($urandom_range(0, 1) == 1) c = c ^ 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] vary_case(input logic [7:0] c);
    if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1) == 1
        && (fold_on || $urandom_range(0, 7) == 0)) return c ^ 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] pick_byte(input int unsigned span);
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (span != 0 && r < 45) begin
      k = $urandom_range(0, span - 1);
      return vary_case(pat_bits[k*8 +: 8]);
    end
    if (r < 80) return rand_letter();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int idle_level();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 40;
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b, input bit fs, input bit le);
    text_queue.push_back({b, fs, le});
    items_made++;
  endtask

  task automatic push_text(input string s, input bit fs);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], fs && i == 0, i == s.len() - 1);
  endtask

  task automatic push_line(input bit fs);
    logic [7:0]  body [$];
    int unsigned span;
    int          n;
    int          at;
    span = active_len();
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 40) : $urandom_range(1, span + 8);
    for (int i = 0; i < n; i++) body.push_back(pick_byte(span));
    if (span != 0 && span <= n && $urandom_range(0, 99) < 45) begin
      at = $urandom_range(0, n - span);
      for (int j = 0; j < span; j++) body[at + j] = vary_case(pat_bits[j*8 +: 8]);
    end
    if ($urandom_range(0, 3) != 0) body.push_back(NL);
    foreach (body[i]) push_byte(body[i], fs && i == 0, i == body.size() - 1);
  endtask

  task automatic run_phase(input int target, input int g, input int s);
    int goal;
    int lines;
    gap_pct = g;
    stall_pct = s;
    if (open_line) push_line(1'b0);
    goal = items_made + target;
    while (items_made < goal) begin
      if ($urandom_range(0, 99) < 8) begin
        repeat ($urandom_range(1, 4))
          push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                    $urandom_range(0, 2) == 0);
      end else begin
        lines = $urandom_range(1, 8);
        for (int i = 0; i < lines; i++) push_line(i == 0);
      end
    end
    open_line = $urandom_range(0, 1);
    if (open_line) begin
      repeat ($urandom_range(1, 4)) push_byte(pick_byte(active_len()), 1'b0, 1'b0);
    end
  endtask

  task automatic random_config();
    logic [127:0] p;
    logic [4:0]   len;
    bit           letters;
    int           r;
    letters = $urandom_range(0, 1);
    for (int k = 0; k < NPAT; k++)
      p[k*8 +: 8] = letters ? rand_letter() : 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 10) len = 5'd0;
    else if (r < 22) len = 5'd16;
    else if (r < 30) len = 5'($urandom_range(17, 31));
    else if (r < 45) len = 5'($urandom_range(9, 15));
    else len = 5'($urandom_range(1, 8));
    set_config(p[63:0], p[127:64], len, $urandom_range(0, 1), $urandom_range(0, 1));
  endtask

  initial begin
    text_ch.valid = 1'b0;
    text_ch.data = '0;
    hit_ch.ready = 1'b0;
    reg_ch.valid = 1'b0;
    reg_ch.data = '0;
    pat_bits = '0;
    pat_len = '0;
    fold_on = 1'b0;
    first_only = 1'b0;
    forget_line();
    line_no = 32'd1;
    file_closed = 1'b0;
    ever_matched = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty pattern after reset, before any file start.
    gap_pct = 20;
    stall_pct = 20;
    push_text("ab\n", 1'b0);
    push_byte(8'h00, 1'b1, 1'b1);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(NL, 1'b0, 1'b1);

    // Case-folded pattern, a line shorter than it, a match on a final byte.
    set_config({40'd0, "C", "b", "A"}, 64'd0, 5'd3, 1'b1, 1'b0);
    push_text("xaBc\n", 1'b1);
    push_text("ab\n", 1'b0);
    push_text("abc", 1'b0);

    // First match per file closes the file until the next file start.
    set_config({40'd0, "C", "b", "A"}, 64'd0, 5'd3, 1'b1, 1'b1);
    push_text("abc\n", 1'b1);
    push_text("abc", 1'b0);
    push_text("abc", 1'b1);

    set_config('1, '1, 5'd31, 1'b0, 1'b0);
    run_phase(125, idle_level(), idle_level());
    set_config({"QrStUvWx"}, {"AbCdEfGh"}, 5'd16, 1'b1, 1'b1);
    run_phase(125, idle_level(), idle_level());

    for (int p = 0; p < 8; p++) begin
      random_config();
      if (p == 3) begin
        run_phase(62, 30, 30);
        wait_idle();
        run_phase(62, 30, 30);
      end else begin
        run_phase(125, idle_level(), idle_level());
      end
    end

    random_config();
    run_phase(125, 0, 0);
    wait_idle();

    $display("Run covered %0d text bytes under %0d register settings.",
             bytes_in, settings_used + 1);
    $display("%0d match results were checked.", results_seen);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
